// File: design/mot_pkg.sv
// ----------------------------------------------------------------------------
// mot_pkg
// Shared types, codes and helpers for the MIDI output packer with note
// tracking: op codes, status nibbles, sequencer states and the request
// that the sequencer hands to the packer.
// ----------------------------------------------------------------------------
`default_nettype none

package mot_pkg;

  localparam int MOT_BUFFER_BYTES = 256;
  localparam int MOT_CHANNELS     = 16;
  localparam int CHUNK_BITS       = 32;

  // input op codes
  localparam logic [1:0] OP_EVENT   = 2'd0;
  localparam logic [1:0] OP_FLUSH   = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;

  // result kinds
  localparam logic KIND_MSG    = 1'b0;
  localparam logic KIND_MARKER = 1'b1;

  // status byte upper nibbles
  localparam logic [3:0] TYPE_NOTE_OFF  = 4'h8;
  localparam logic [3:0] TYPE_NOTE_ON   = 4'h9;
  localparam logic [3:0] TYPE_PROG_CHG  = 4'hC;
  localparam logic [3:0] TYPE_CHAN_PRES = 4'hD;
  localparam logic [7:0] STATUS_REALTIME_MIN = 8'hF8;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_SEND,
    S_SCAN
  } mot_state_t;

  // one message (or flush) request from the sequencer to the packer
  typedef struct packed {
    logic       flush;
    logic [7:0] status;
    logic [6:0] data1;
    logic [6:0] data2;
    logic       last;
  } mot_req_t;

  // bytes a message takes in the batch
  function automatic logic [1:0] msg_len_f(input logic [7:0] status);
    logic [1:0] len;
    if (status >= STATUS_REALTIME_MIN) begin
      len = 2'd1;
    end else if (status[7:4] == TYPE_PROG_CHG || status[7:4] == TYPE_CHAN_PRES) begin
      len = 2'd2;
    end else begin
      len = 2'd3;
    end
    return len;
  endfunction

endpackage

`default_nettype wire

// File: design/midi_out_packer_note_tracker.sv
// ----------------------------------------------------------------------------
// midi_out_packer_note_tracker
// MIDI output batcher with active-note tracking over a 64 x 32 bitmap memory.
// ----------------------------------------------------------------------------
// Event requests: accept, then bitmap read and handoff in S_LOOK; flush
//   requests: accept, then handoff in S_SEND, where a stalled event handoff
//   also waits. The first result is valid in the cycle after handoff.
// Release requests: accept, bitmap read in S_LOOK, then an S_SCAN walk of
//   one note position per cycle, held while a note-off waits for the packer,
//   up to the highest active note. Untracked-channel releases and the unused
//   op end in S_IDLE. A marker is output ahead of its held message.
// Reset (rst_n, synchronous): fill count, side and control clear at once;
//   the bitmap reads as empty through per-row valid flags, no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module midi_out_packer_note_tracker
  import mot_pkg::*;
#(
  parameter int BUFFER_BYTES = MOT_BUFFER_BYTES,
  parameter int CHANNELS     = MOT_CHANNELS
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output      logic       in_ready,
  input  wire logic [1:0] in_op,
  input  wire logic [7:0] in_status,
  input  wire logic [6:0] in_data1,
  input  wire logic [6:0] in_data2,
  input  wire logic [3:0] in_release_channel,
  input  wire logic [1:0] in_release_chunk,
  output      logic       out_valid,
  input  wire logic       out_ready,
  output      logic       out_kind,
  output      logic [7:0] out_msg_status,
  output      logic [6:0] out_msg_data1,
  output      logic [6:0] out_msg_data2,
  output      logic [1:0] out_msg_len,
  output      logic [8:0] out_batch_bytes,
  output      logic       out_batch_side,
  output      logic       out_last
);

  localparam int         DEPTH  = CHANNELS * 4;
  localparam int         AW     = $clog2(DEPTH);
  localparam logic [4:0] CH_CNT = 5'(CHANNELS);

  mot_state_t state_r, state_nxt;

  // captured request
  logic [1:0] op_r;
  logic [7:0] st_r;
  logic [6:0] d1_r;
  logic [6:0] d2_r;
  logic [3:0] rch_r;
  logic [1:0] rck_r;

  // release walk
  logic [CHUNK_BITS-1:0] mask_r, mask_nxt;
  logic [4:0]            b_r, b_nxt;

  logic [5:0]            in_row;
  logic [5:0]            cur_row;
  logic [AW-1:0]         rd_addr;
  logic [AW-1:0]         wr_addr;
  logic [CHUNK_BITS-1:0] rd_data;
  logic [CHUNK_BITS-1:0] wr_data;
  logic                  wr_en;
  logic [CHUNK_BITS-1:0] note_bit;
  logic                  ev_ch_ok;
  logic                  rel_ch_ok;
  logic                  accept;

  logic                  req_valid;
  logic                  req_ready;
  mot_req_t              req;
  mot_req_t              ev_req;
  mot_req_t              fl_req;
  mot_req_t              off_req;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign rel_ch_ok = {1'b0, in_release_channel} < CH_CNT;
  assign ev_ch_ok  = {1'b0, st_r[3:0]} < CH_CNT;

  // row = channel * 4 + chunk; in range rows fit the address width
  assign in_row  = (in_op == OP_EVENT) ? {in_status[3:0], in_data1[6:5]}
                                       : {in_release_channel, in_release_chunk};
  assign cur_row = (op_r == OP_EVENT) ? {st_r[3:0], d1_r[6:5]} : {rch_r, rck_r};
  assign rd_addr = in_row[AW-1:0];
  assign wr_addr = cur_row[AW-1:0];

  assign note_bit = CHUNK_BITS'(1) << d1_r[4:0];

  assign ev_req  = '{flush: 1'b0, status: st_r, data1: d1_r, data2: d2_r, last: 1'b1};
  assign fl_req  = '{flush: 1'b1, status: '0, data1: '0, data2: '0, last: 1'b1};
  // note-off for the current bit, last when no higher note remains
  assign off_req = '{flush: 1'b0, status: {TYPE_NOTE_OFF, rch_r}, data1: {rck_r, b_r},
                     data2: '0, last: (mask_r[CHUNK_BITS-1:1] == '0)};

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_op;
      st_r  <= in_status;
      d1_r  <= in_data1;
      d2_r  <= in_data2;
      rch_r <= in_release_channel;
      rck_r <= in_release_chunk;
    end
    mask_r <= mask_nxt;
    b_r    <= b_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    wr_en     = 1'b0;
    wr_data   = '0;
    req_valid = 1'b0;
    req       = ev_req;
    mask_nxt  = mask_r;
    b_nxt     = b_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_op)
            OP_EVENT: state_nxt = S_LOOK;
            OP_FLUSH: state_nxt = S_SEND;
            OP_RELEASE: begin
              // untracked channels release nothing
              if (rel_ch_ok) begin
                state_nxt = S_LOOK;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      S_LOOK: begin
        if (op_r == OP_EVENT) begin
          // update the note bit, hand the message over
          wr_en     = ev_ch_ok &&
                      (st_r[7:4] == TYPE_NOTE_ON || st_r[7:4] == TYPE_NOTE_OFF);
          wr_data   = (st_r[7:4] == TYPE_NOTE_ON) ? (rd_data | note_bit)
                                                  : (rd_data & ~note_bit);
          req_valid = 1'b1;
          req       = ev_req;
          state_nxt = req_ready ? S_IDLE : S_SEND;
        end else begin
          // clear the chunk, walk its old contents
          wr_en     = 1'b1;
          wr_data   = '0;
          mask_nxt  = rd_data;
          b_nxt     = '0;
          state_nxt = S_SCAN;
        end
      end

      S_SEND: begin
        req_valid = 1'b1;
        req       = (op_r == OP_FLUSH) ? fl_req : ev_req;
        if (req_ready) begin
          state_nxt = S_IDLE;
        end
      end

      S_SCAN: begin
        req = off_req;
        if (mask_r == '0) begin
          state_nxt = S_IDLE;
        end else if (mask_r[0]) begin
          req_valid = 1'b1;
          if (req_ready) begin
            mask_nxt = mask_r >> 1;
            b_nxt    = b_r + 5'd1;
            if (off_req.last) begin
              state_nxt = S_IDLE;
            end
          end
        end else begin
          // skip an inactive note
          mask_nxt = mask_r >> 1;
          b_nxt    = b_r + 5'd1;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  mot_note_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  mot_packer #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_packer (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req_valid),
    .req             (req),
    .req_ready       (req_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_msg_status  (out_msg_status),
    .out_msg_data1   (out_msg_data1),
    .out_msg_data2   (out_msg_data2),
    .out_msg_len     (out_msg_len),
    .out_batch_bytes (out_batch_bytes),
    .out_batch_side  (out_batch_side),
    .out_last        (out_last)
  );

endmodule

`default_nettype wire

// File: design/mot_note_mem.sv
// ----------------------------------------------------------------------------
// mot_note_mem
// Active-note bitmap store: one 32-bit row per channel and chunk, one write
// port, one registered read port. Per-row valid flags make every row read
// as zero after reset until it is first written.
// ----------------------------------------------------------------------------
`default_nettype none

module mot_note_mem
  import mot_pkg::*;
#(
  parameter int DEPTH = MOT_CHANNELS * 4
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [CHUNK_BITS-1:0]    rd_data,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [CHUNK_BITS-1:0]    wr_data
);

  logic [CHUNK_BITS-1:0] mem [DEPTH];
  logic [DEPTH-1:0]      vld_r;
  logic [CHUNK_BITS-1:0] rdata_r;
  logic                  rvld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      rvld_r <= vld_r[rd_addr];
    end
  end

  // unwritten rows hold no active notes
  assign rd_data = rvld_r ? rdata_r : '0;

endmodule

`default_nettype wire

// File: design/mot_packer.sv
// ----------------------------------------------------------------------------
// mot_packer
// Batch accounting and result register: tracks fill count and active
// ping-pong side, emits a batch marker on a flush of a non-empty batch or
// ahead of a message that overflows, and holds that message until the output register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module mot_packer
  import mot_pkg::*;
#(
  parameter int BUFFER_BYTES = MOT_BUFFER_BYTES
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       req_valid,
  input  wire mot_req_t   req,
  output      logic       req_ready,
  output      logic       out_valid,
  input  wire logic       out_ready,
  output      logic       out_kind,
  output      logic [7:0] out_msg_status,
  output      logic [6:0] out_msg_data1,
  output      logic [6:0] out_msg_data2,
  output      logic [1:0] out_msg_len,
  output      logic [8:0] out_batch_bytes,
  output      logic       out_batch_side,
  output      logic       out_last
);

  localparam int FILL_W = $clog2(BUFFER_BYTES + 1);

  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              side_r, side_nxt;
  logic              pend_r, pend_nxt;
  logic              ovld_r, ovld_nxt;

  logic       kind_r, kind_nxt;
  logic [7:0] st_r, st_nxt;
  logic [6:0] d1_r, d1_nxt;
  logic [6:0] d2_r, d2_nxt;
  logic [1:0] len_r, len_nxt;
  logic [8:0] bytes_r, bytes_nxt;
  logic       oside_r, oside_nxt;
  logic       last_r, last_nxt;

  logic [7:0] p_st_r, p_st_nxt;
  logic [6:0] p_d1_r, p_d1_nxt;
  logic [6:0] p_d2_r, p_d2_nxt;
  logic [1:0] p_len_r, p_len_nxt;
  logic       p_last_r, p_last_nxt;

  logic              can_load;
  logic [1:0]        len;
  logic [FILL_W:0]   sum;
  logic              ovf;
  logic [6:0]        d1m;
  logic [6:0]        d2m;
  logic [FILL_W+8:0] fill_ext;
  logic [8:0]        fill_bytes;

  assign can_load   = !ovld_r || out_ready;
  assign req_ready  = !pend_r && can_load;
  assign len        = msg_len_f(req.status);
  assign sum        = {1'b0, fill_r} + (FILL_W + 1)'(len);
  assign ovf        = sum > (FILL_W + 1)'(BUFFER_BYTES);
  assign d1m        = (len != 2'd1) ? req.data1 : '0;
  assign d2m        = (len == 2'd3) ? req.data2 : '0;
  assign fill_ext   = (FILL_W + 9)'(fill_r);
  assign fill_bytes = fill_ext[8:0];

  always_comb begin
    fill_nxt   = fill_r;
    side_nxt   = side_r;
    pend_nxt   = pend_r;
    ovld_nxt   = ovld_r;
    kind_nxt   = kind_r;
    st_nxt     = st_r;
    d1_nxt     = d1_r;
    d2_nxt     = d2_r;
    len_nxt    = len_r;
    bytes_nxt  = bytes_r;
    oside_nxt  = oside_r;
    last_nxt   = last_r;
    p_st_nxt   = p_st_r;
    p_d1_nxt   = p_d1_r;
    p_d2_nxt   = p_d2_r;
    p_len_nxt  = p_len_r;
    p_last_nxt = p_last_r;

    if (ovld_r && out_ready) begin
      ovld_nxt = 1'b0;
    end

    if (pend_r && can_load) begin
      // release the message held back behind its marker
      ovld_nxt  = 1'b1;
      pend_nxt  = 1'b0;
      kind_nxt  = KIND_MSG;
      st_nxt    = p_st_r;
      d1_nxt    = p_d1_r;
      d2_nxt    = p_d2_r;
      len_nxt   = p_len_r;
      bytes_nxt = '0;
      oside_nxt = side_r;
      last_nxt  = p_last_r;
    end else if (req_valid && req_ready) begin
      if (req.flush) begin
        if (fill_r != '0) begin
          ovld_nxt  = 1'b1;
          kind_nxt  = KIND_MARKER;
          st_nxt    = '0;
          d1_nxt    = '0;
          d2_nxt    = '0;
          len_nxt   = '0;
          bytes_nxt = fill_bytes;
          oside_nxt = side_r;
          last_nxt  = req.last;
          side_nxt  = !side_r;
          fill_nxt  = '0;
        end
      end else if (ovf) begin
        // send the full batch first, hold the message
        ovld_nxt   = 1'b1;
        kind_nxt   = KIND_MARKER;
        st_nxt     = '0;
        d1_nxt     = '0;
        d2_nxt     = '0;
        len_nxt    = '0;
        bytes_nxt  = fill_bytes;
        oside_nxt  = side_r;
        last_nxt   = 1'b0;
        side_nxt   = !side_r;
        fill_nxt   = FILL_W'(len);
        pend_nxt   = 1'b1;
        p_st_nxt   = req.status;
        p_d1_nxt   = d1m;
        p_d2_nxt   = d2m;
        p_len_nxt  = len;
        p_last_nxt = req.last;
      end else begin
        ovld_nxt  = 1'b1;
        kind_nxt  = KIND_MSG;
        st_nxt    = req.status;
        d1_nxt    = d1m;
        d2_nxt    = d2m;
        len_nxt   = len;
        bytes_nxt = '0;
        oside_nxt = side_r;
        last_nxt  = req.last;
        fill_nxt  = sum[FILL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      side_r <= 1'b0;
      pend_r <= 1'b0;
      ovld_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      side_r <= side_nxt;
      pend_r <= pend_nxt;
      ovld_r <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    st_r     <= st_nxt;
    d1_r     <= d1_nxt;
    d2_r     <= d2_nxt;
    len_r    <= len_nxt;
    bytes_r  <= bytes_nxt;
    oside_r  <= oside_nxt;
    last_r   <= last_nxt;
    p_st_r   <= p_st_nxt;
    p_d1_r   <= p_d1_nxt;
    p_d2_r   <= p_d2_nxt;
    p_len_r  <= p_len_nxt;
    p_last_r <= p_last_nxt;
  end

  assign out_valid       = ovld_r;
  assign out_kind        = kind_r;
  assign out_msg_status  = st_r;
  assign out_msg_data1   = d1_r;
  assign out_msg_data2   = d2_r;
  assign out_msg_len     = len_r;
  assign out_batch_bytes = bytes_r;
  assign out_batch_side  = oside_r;
  assign out_last        = last_r;

endmodule

`default_nettype wire
